// ----- src/scalar_kalman_filter_defines.svh -----
// Assertion macros used by the checker file.
`ifndef SCALAR_KALMAN_FILTER_DEFINES_SVH
`define SCALAR_KALMAN_FILTER_DEFINES_SVH

// Same-cycle implication.
`define SKF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("skf assertion failed");

// Next-cycle implication.
`define SKF_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("skf assertion failed");

`endif

// ----- src/skf_pkg.sv -----
package skf_pkg;

   localparam int SAMPLE_BITS_DEF = 16;
   localparam int GAIN_BITS_DEF   = 16;

   localparam int CFG_BITS      = 24;  // config register width
   localparam int CSR_IDX_BITS  = 2;
   localparam int COV_BITS      = 25;  // covariance, Q9.16 unsigned
   localparam int DEN_BITS      = COV_BITS + 1;
   localparam int ACC_BITS      = 32;  // estimate accumulator, Q16.16 signed
   localparam int DIFF_BITS     = ACC_BITS + 1;
   localparam int EST_BITS      = 24;  // Q16.8 output
   localparam int GAIN_OUT_BITS = 16;
   localparam int FRAC_BITS     = 16;

   localparam logic [CFG_BITS-1:0] Q_RESET = CFG_BITS'(66);
   localparam logic [CFG_BITS-1:0] R_RESET = CFG_BITS'(35586);
   localparam logic [CFG_BITS-1:0] P_RESET = CFG_BITS'(1311);

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_PROCESS_NOISE = 2'd0,
      CSR_MEAS_NOISE    = 2'd1,
      CSR_INIT_COV      = 2'd2
   } skf_csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_MUL_EST,
      ST_MUL_COV,
      ST_RESP
   } skf_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } skf_div_stat_type;

endpackage

// ----- src/skf_ifs.sv -----
interface skf_req_if import skf_pkg::*; #(parameter int SAMPLE_BITS = SAMPLE_BITS_DEF);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   modport source (output valid, sample, input ready);
   modport sink   (input valid, sample, output ready);
endinterface

interface skf_rsp_if import skf_pkg::*;;
   logic                       valid;
   logic                       ready;
   logic signed [EST_BITS-1:0] estimate;
   logic [GAIN_OUT_BITS-1:0]   gain;
   modport source (output valid, estimate, gain, input ready);
   modport sink   (input valid, estimate, gain, output ready);
endinterface

interface skf_csr_if import skf_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic [CSR_IDX_BITS-1:0] index;
   logic [CFG_BITS-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/skf_div.sv -----
// Restoring divider, one quotient bit per cycle. Expects num <= den.
module skf_div import skf_pkg::*; #(
   parameter int GAIN_BITS = GAIN_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [COV_BITS-1:0] num,
   input  logic [DEN_BITS-1:0] den,
   output skf_div_stat_type    stat,
   output logic [GAIN_BITS:0]  quo
);

   localparam int REM_BITS = DEN_BITS + 1;
   localparam int CNT_BITS = $clog2(GAIN_BITS + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [REM_BITS-1:0] rem_ff, rem_in;
   logic [DEN_BITS-1:0] den_ff, den_in;
   logic [GAIN_BITS:0]  quo_ff, quo_in;

   logic [REM_BITS-1:0] trial;
   logic [REM_BITS-1:0] trial_sub;
   logic                fits;

   always_comb begin
      // first step compares unshifted: catches quotient == 2^GAIN_BITS
      trial     = (cnt_ff == '0) ? rem_ff : {rem_ff[REM_BITS-2:0], 1'b0};
      fits      = trial >= {1'b0, den_ff};
      trial_sub = trial - {1'b0, den_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = REM_BITS'(num);
         den_in  = den;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? trial_sub : trial;
         quo_in = {quo_ff[GAIN_BITS-1:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_BITS'(GAIN_BITS)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quo       = quo_ff;

endmodule

// ----- src/skf_mul.sv -----
// Shared multiplier: unsigned a times signed b, product registered.
module skf_mul import skf_pkg::*; #(
   parameter int A_BITS = GAIN_BITS_DEF + 1,
   parameter int B_BITS = DIFF_BITS
) (
   input  logic                            clock,
   input  logic                            en,
   input  logic [A_BITS-1:0]               a,
   input  logic signed [B_BITS-1:0]        b,
   output logic signed [A_BITS+B_BITS:0]   p
);

   logic signed [A_BITS+B_BITS:0] p_ff, p_in;

   always_comb begin
      p_in = p_ff;
      if (en) begin
         p_in = $signed({1'b0, a}) * b;
      end
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

   assign p = p_ff;

endmodule

// ----- src/scalar_kalman_filter.sv -----
// Sequence from sample acceptance to result valid: prep, GAIN_BITS+1 divider
//   steps, gain capture, two multiplies, update/output.
// Sample handling: one sample at a time; the next is taken only back in idle, later
//   while a result waits on rsp ready; the gain divider iterates one bit per cycle and
//   the one multiplier serves two products.
// Reset (synchronous, active high): q=66, r=35586, covariance=1311, estimate 0,
//   sequencer idle, no result pending. CSR writes are taken every cycle.
module scalar_kalman_filter import skf_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int GAIN_BITS   = GAIN_BITS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   skf_req_if.sink  req_chan,
   skf_rsp_if.source rsp_chan,
   skf_csr_if.sink  csr_chan
);

   // Shared multiplier: gain-side operand is GAIN_BITS+1 wide (holds 2^G - k),
   // data-side operand is the 33 bit signed difference or the covariance.
   localparam int MA_BITS   = GAIN_BITS + 1;
   localparam int MB_BITS   = DIFF_BITS;
   localparam int PROD_BITS = MA_BITS + MB_BITS + 1;
   localparam int STEP_BITS = DIFF_BITS + 1;
   // target before saturation: sample scaled by 2^16
   localparam int TGT_RAW   = SAMPLE_BITS + FRAC_BITS;
   localparam int TGT_BITS  = (TGT_RAW > ACC_BITS) ? TGT_RAW : ACC_BITS;
   localparam int KEXT_BITS = (GAIN_BITS > GAIN_OUT_BITS) ? GAIN_BITS : GAIN_OUT_BITS;

   localparam logic [MA_BITS-1:0]   GAIN_ONE  = MA_BITS'(1) << GAIN_BITS;
   localparam logic [PROD_BITS-1:0] GAIN_HALF = PROD_BITS'(1) << (GAIN_BITS - 1);

   // ---------------------------------------------------------------------------
   // State
   // ---------------------------------------------------------------------------
   skf_state_type state_ff, state_in;

   logic [CFG_BITS-1:0]           q_ff, q_in;       // process noise
   logic [CFG_BITS-1:0]           r_ff, r_in;       // measurement noise
   logic signed [ACC_BITS-1:0]    acc_ff, acc_in;   // estimate, Q16.16
   logic [COV_BITS-1:0]           cov_ff, cov_in;   // covariance, Q9.16

   // per-transaction working registers
   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic [COV_BITS-1:0]           pp_ff, pp_in;     // predicted covariance
   logic signed [DIFF_BITS-1:0]   diff_ff, diff_in; // target - estimate
   logic                          dzero_ff, dzero_in;
   logic [GAIN_BITS-1:0]          k_ff, k_in;

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [EST_BITS-1:0]    rsp_est_ff, rsp_est_in;
   logic [GAIN_OUT_BITS-1:0]      rsp_gain_ff, rsp_gain_in;

   // ---------------------------------------------------------------------------
   // Datapath helpers
   // ---------------------------------------------------------------------------
   logic [DEN_BITS-1:0]           pp_sum;
   logic [COV_BITS-1:0]           pp_sat;
   logic [DEN_BITS-1:0]           den;
   logic signed [TGT_BITS-1:0]    tgt_wide;
   logic signed [ACC_BITS-1:0]    target;
   logic signed [DIFF_BITS-1:0]   diff;

   skf_div_stat_type              div_stat;
   logic                          div_start;
   logic [GAIN_BITS:0]            div_quo;
   logic [GAIN_BITS-1:0]          k_sat;

   logic                          mul_en;
   logic [MA_BITS-1:0]            mul_a;
   logic signed [MB_BITS-1:0]     mul_b;
   logic signed [PROD_BITS-1:0]   mul_p;
   logic signed [PROD_BITS-1:0]   prod_rnd;
   logic signed [PROD_BITS-1:0]   prod_shr;
   logic signed [STEP_BITS-1:0]   acc_sum;
   logic signed [ACC_BITS-1:0]    acc_sat;
   logic [COV_BITS-1:0]           cov_new;

   logic signed [ACC_BITS:0]      est_rnd;
   logic signed [ACC_BITS:0]      est_shr;
   logic signed [EST_BITS-1:0]    est_sat;
   logic [KEXT_BITS-1:0]          k_ext;

   logic req_fire;
   logic rsp_free;

   skf_div #(
      .GAIN_BITS (GAIN_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (pp_ff),
      .den   (den),
      .stat  (div_stat),
      .quo   (div_quo)
   );

   skf_mul #(
      .A_BITS (MA_BITS),
      .B_BITS (MB_BITS)
   ) u_mul (
      .clock (clock),
      .en    (mul_en),
      .a     (mul_a),
      .b     (mul_b),
      .p     (mul_p)
   );

   always_comb begin
      // p' = min(p + q, 2^25-1)
      pp_sum = {1'b0, cov_ff} + DEN_BITS'(q_ff);
      pp_sat = pp_sum[DEN_BITS-1] ? '1 : pp_sum[COV_BITS-1:0];
      den    = {1'b0, pp_ff} + DEN_BITS'(r_ff);

      // sample in Q16.16, clamped to the accumulator range
      tgt_wide = TGT_BITS'(sample_ff) <<< FRAC_BITS;
      if ((&tgt_wide[TGT_BITS-1:ACC_BITS-1]) || !(|tgt_wide[TGT_BITS-1:ACC_BITS-1])) begin
         target = tgt_wide[ACC_BITS-1:0];
      end else begin
         target = tgt_wide[TGT_BITS-1] ? {1'b1, {(ACC_BITS-1){1'b0}}}
                                       : {1'b0, {(ACC_BITS-1){1'b1}}};
      end
      diff = DIFF_BITS'(target) - DIFF_BITS'(acc_ff);

      // gain: zero for a zero denominator, saturate when quotient hits 2^G
      if (dzero_ff) begin
         k_sat = '0;
      end else if (div_quo[GAIN_BITS]) begin
         k_sat = '1;
      end else begin
         k_sat = div_quo[GAIN_BITS-1:0];
      end

      // multiplier operands: k*diff first, then (1-k)*p'
      mul_en = (state_ff == ST_MUL_EST) || (state_ff == ST_MUL_COV);
      if (state_ff == ST_MUL_EST) begin
         mul_a = {1'b0, k_ff};
         mul_b = diff_ff;
      end else begin
         mul_a = GAIN_ONE - {1'b0, k_ff};
         mul_b = $signed(MB_BITS'(pp_ff));
      end

      // round and scale the product; floor via arithmetic shift
      prod_rnd = mul_p + $signed(GAIN_HALF);
      prod_shr = prod_rnd >>> GAIN_BITS;
      acc_sum  = STEP_BITS'(acc_ff) + $signed(prod_shr[STEP_BITS-1:0]);
      if ((&acc_sum[STEP_BITS-1:ACC_BITS-1]) || !(|acc_sum[STEP_BITS-1:ACC_BITS-1])) begin
         acc_sat = acc_sum[ACC_BITS-1:0];
      end else begin
         acc_sat = acc_sum[STEP_BITS-1] ? {1'b1, {(ACC_BITS-1){1'b0}}}
                                        : {1'b0, {(ACC_BITS-1){1'b1}}};
      end
      // (1-k)*p' never exceeds p', so no clamp is needed
      cov_new = prod_rnd[GAIN_BITS+COV_BITS-1:GAIN_BITS];

      // Q16.16 -> Q16.8, round half up, clamp to 24 bits
      est_rnd = (ACC_BITS+1)'(acc_ff) + (ACC_BITS+1)'(128);
      est_shr = est_rnd >>> 8;
      if (est_shr[EST_BITS] == est_shr[EST_BITS-1]) begin
         est_sat = est_shr[EST_BITS-1:0];
      end else begin
         est_sat = est_shr[EST_BITS] ? {1'b1, {(EST_BITS-1){1'b0}}}
                                     : {1'b0, {(EST_BITS-1){1'b1}}};
      end
      k_ext = KEXT_BITS'(k_ff);
   end

   // ---------------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------------
   assign req_fire = req_chan.valid && (state_ff == ST_IDLE);
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in     = state_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      acc_in       = acc_ff;
      cov_in       = cov_ff;
      sample_in    = sample_ff;
      pp_in        = pp_ff;
      diff_in      = diff_ff;
      dzero_in     = dzero_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_est_in   = rsp_est_ff;
      rsp_gain_in  = rsp_gain_ff;
      div_start    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               sample_in = req_chan.sample;
               pp_in     = pp_sat;
               state_in  = ST_PREP;
            end
         end
         ST_PREP: begin
            diff_in   = diff;
            dzero_in  = (den == '0);
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_stat.done) begin
               k_in     = k_sat;
               state_in = ST_MUL_EST;
            end
         end
         ST_MUL_EST: begin
            state_in = ST_MUL_COV;
         end
         ST_MUL_COV: begin
            // estimate product is in the multiplier register this cycle
            acc_in   = acc_sat;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            // covariance product is held until the output slot frees up
            if (rsp_free) begin
               cov_in       = cov_new;
               rsp_valid_in = 1'b1;
               rsp_est_in   = est_sat;
               rsp_gain_in  = k_ext[GAIN_OUT_BITS-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // CSR writes are taken in any state; an index past the last register is dropped
      if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_PROCESS_NOISE: q_in = csr_chan.data;
            CSR_MEAS_NOISE:    r_in = csr_chan.data;
            CSR_INIT_COV: begin
               cov_in = COV_BITS'(csr_chan.data);
               acc_in = '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         q_ff         <= Q_RESET;
         r_ff         <= R_RESET;
         acc_ff       <= '0;
         cov_ff       <= COV_BITS'(P_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         q_ff         <= q_in;
         r_ff         <= r_in;
         acc_ff       <= acc_in;
         cov_ff       <= cov_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff   <= sample_in;
      pp_ff       <= pp_in;
      diff_ff     <= diff_in;
      dzero_ff    <= dzero_in;
      k_ff        <= k_in;
      rsp_est_ff  <= rsp_est_in;
      rsp_gain_ff <= rsp_gain_in;
   end

   assign req_chan.ready    = (state_ff == ST_IDLE);
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.estimate = rsp_est_ff;
   assign rsp_chan.gain     = rsp_gain_ff;
   assign csr_chan.ready    = 1'b1;

endmodule

// ----- src/skf_checker.sv -----
`include "scalar_kalman_filter_defines.svh"

module skf_checker import skf_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic signed [EST_BITS-1:0] rsp_estimate,
   input logic [GAIN_OUT_BITS-1:0]   rsp_gain
);

   // reset leaves the block idle with nothing to deliver
   `SKF_ASSERT_NXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid && req_ready)

   // one transaction at a time: busy right after accepting
   `SKF_ASSERT_NXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)

   // a result never appears the cycle after a sample is taken
   `SKF_ASSERT_NXT(a_no_instant_rsp, clock, reset, req_valid && req_ready, !$rose(rsp_valid))

   // stalled result holds
   `SKF_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_estimate) && $stable(rsp_gain))

endmodule

bind scalar_kalman_filter skf_checker u_skf_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_estimate (rsp_chan.estimate),
   .rsp_gain     (rsp_chan.gain)
);
